>>> hdl/hhg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhg_pkg
// Types and constants shared by the humidifier hysteresis guard modules.
// ----------------------------------------------------------------------------
package hhg_pkg;

    localparam int unsigned MS_PER_SEC = 1000;

    // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT, exact for x < 2^28
    localparam logic [28:0] RECIP_125   = 29'd274877907;
    localparam int unsigned RECIP_SHIFT = 35;

    localparam int unsigned APB_AW = 5;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_MAX_RUN    = 3'd0;
    localparam logic [2:0] REG_HOLD       = 3'd1;
    localparam logic [2:0] REG_LOCKOUT    = 3'd2;
    localparam logic [2:0] REG_DWELL      = 3'd3;
    localparam logic [2:0] REG_ON_BELOW   = 3'd4;
    localparam logic [2:0] REG_OFF_ABOVE  = 3'd5;
    localparam logic [2:0] REG_INITIAL_ON = 3'd6;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_SET    = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_AUTO   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        RSN_BOOT     = 4'd0,
        RSN_DRY      = 4'd1,
        RSN_WET      = 4'd2,
        RSN_DEADBAND = 4'd3,
        RSN_DWELL    = 4'd4,
        RSN_MANUAL   = 4'd5,
        RSN_MAXRUN   = 4'd6,
        RSN_LOCKOUT  = 4'd7,
        RSN_SENSOR   = 4'd8,
        RSN_NOCODE   = 4'd9
    } reason_t;

    typedef struct packed {
        logic [19:0] run_limit_sec;
        logic [29:0] max_run_ms;
        logic [19:0] hold_sec;
        logic [29:0] hold_ms;
        logic [19:0] lock_sec;
        logic [29:0] lock_ms;
        logic [19:0] dwell_limit_sec;
        logic [29:0] dwell_ms;
        logic [9:0]  on_below;
        logic [9:0]  off_above;
        logic        initial_on;
    } cfg_t;

    typedef struct packed {
        logic    machine_on;
        logic    overriding;
        reason_t reason;
        logic    fire;
        logic    fire_level;
        logic    lockout;
    } status_t;

endpackage : hhg_pkg
`default_nettype wire

>>> hdl/humidifier_hysteresis_guard_top.sv
`default_nettype none
// Pipeline: input register, decision register, seconds-conversion register and
//   output register.
// Throughput: one item per cycle unless the output stalls.
// Back-pressure is absorbed by empty pipeline slots before ready drops.
// Reset (rst_n low, asynchronous): registers take their defaults, guard state
//   clears, machine_on belief goes off, pipeline empties.
// ----------------------------------------------------------------------------
// humidifier_hysteresis_guard_top
// Humidifier on/off guard with max-run cut, override hold, refill lockout,
// hysteresis thresholds and minimum dwell.
// ----------------------------------------------------------------------------
module humidifier_hysteresis_guard_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hhg_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output      logic [31:0]                prdata,
    output      logic                       pready,
    input  wire logic                       s_axis_tvalid,
    output      logic                       s_axis_tready,
    // [31:0] now_ms, [41:32] humidity, [42] sensor_ok, [43] manual_on,
    // [44] emitter_ready, [47:45] zero
    input  wire logic [47:0]                s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]                 s_axis_tuser,
    output      logic                       m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [0] machine_on, [1] overriding, [5:2] reason, [6] fire, [7] fire_level,
    // [29:8] state_age_sec, [49:30] override_left_sec, [69:50] dwell_left_sec,
    // [89:70] lockout_left_sec, [95:90] zero
    output      logic [95:0]                m_axis_tdata
);
    import hhg_pkg::*;

    cfg_t cfg;
    logic init_wr;

    hhg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .init_wr (init_wr)
    );

    // elapsed ms as a positive 31-bit value, zero when not positive
    function automatic logic [30:0] pos_ms(input logic [31:0] d);
        return d[31] ? 31'd0 : d[30:0];
    endfunction

    // elapsed seconds >= n, evaluated against n * 1000 ms
    function automatic logic secs_ge(input logic [30:0] dv, input logic [19:0] n,
                                     input logic [29:0] n_ms);
        return (n == 20'd0) || (dv >= {1'b0, n_ms});
    endfunction

    // ---------------- guard state ----------------
    logic        is_on_reg, is_on_next;
    reason_t     reason_reg, reason_next;
    logic [31:0] last_sw_reg, last_sw_next;
    logic [31:0] on_since_reg, on_since_next;
    logic        ov_act_reg, ov_act_next;
    logic [31:0] ov_start_reg, ov_start_next;
    logic        lk_act_reg, lk_act_next;
    logic [31:0] lk_start_reg, lk_start_next;

    // ---------------- pipeline registers ----------------
    logic        a_valid_reg;
    op_t         a_op_reg;
    logic [31:0] a_now_reg;
    logic [9:0]  a_hum_reg;
    logic        a_ok_reg;
    logic        a_mon_reg;
    logic        a_rdy_reg;

    logic        b_valid_reg;
    status_t     b_stat_reg, b_stat_next;
    logic [30:0] b_dage_reg;
    logic [30:0] b_dov_reg;
    logic [30:0] b_dlk_reg;

    logic        c_valid_reg;
    status_t     c_stat_reg;
    logic [21:0] c_age;
    logic [21:0] c_ov_used;
    logic [21:0] c_lk_used;

    logic        d_valid_reg;
    logic [95:0] d_data_reg, d_data_next;

    logic a_ready, b_ready, c_ready, d_ready;
    logic a_adv;

    assign d_ready = !d_valid_reg || m_axis_tready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign a_adv   = a_valid_reg && b_ready;

    assign s_axis_tready = a_ready;
    assign m_axis_tvalid = d_valid_reg;
    assign m_axis_tdata  = d_data_reg;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_axis_tvalid)
        begin
            a_op_reg  <= op_t'(s_axis_tuser);
            a_now_reg <= s_axis_tdata[31:0];
            a_hum_reg <= s_axis_tdata[41:32];
            a_ok_reg  <= s_axis_tdata[42];
            a_mon_reg <= s_axis_tdata[43];
            a_rdy_reg <= s_axis_tdata[44];
        end
    end

    // ---------------- decision ----------------
    logic [30:0] dv_on, dv_ov, dv_lk, dv_ls;
    logic        maxrun_hit, hold_done, lock_done, dwell_done;
    logic        hyst_want;
    reason_t     hyst_why;
    logic        man_want;
    logic        sw_req, sw_want, force_manual;
    reason_t     sw_why;

    assign dv_on = pos_ms(a_now_reg - on_since_reg);
    assign dv_ov = pos_ms(a_now_reg - ov_start_reg);
    assign dv_lk = pos_ms(a_now_reg - lk_start_reg);
    assign dv_ls = pos_ms(a_now_reg - last_sw_reg);

    assign maxrun_hit = secs_ge(dv_on, cfg.run_limit_sec, cfg.max_run_ms);
    assign hold_done  = secs_ge(dv_ov, cfg.hold_sec, cfg.hold_ms);
    assign lock_done  = secs_ge(dv_lk, cfg.lock_sec, cfg.lock_ms);
    assign dwell_done = secs_ge(dv_ls, cfg.dwell_limit_sec, cfg.dwell_ms);

    assign man_want = (a_op_reg == OP_SET) ? a_mon_reg : !is_on_reg;

    always_comb
    begin
        if (a_hum_reg < cfg.on_below)
        begin
            hyst_want = 1'b1;
            hyst_why  = RSN_DRY;
        end
        else if (a_hum_reg > cfg.off_above)
        begin
            hyst_want = 1'b0;
            hyst_why  = RSN_WET;
        end
        else
        begin
            hyst_want = is_on_reg;
            hyst_why  = RSN_DEADBAND;
        end
    end

    always_comb
    begin
        is_on_next    = is_on_reg;
        reason_next   = reason_reg;
        last_sw_next  = last_sw_reg;
        on_since_next = on_since_reg;
        ov_act_next   = ov_act_reg;
        ov_start_next = ov_start_reg;
        lk_act_next   = lk_act_reg;
        lk_start_next = lk_start_reg;
        sw_req        = 1'b0;
        sw_want       = 1'b0;
        sw_why        = RSN_BOOT;
        force_manual  = 1'b0;
        b_stat_next.fire       = 1'b0;
        b_stat_next.fire_level = 1'b0;

        case (a_op_reg)
            OP_UPDATE:
            begin
                if (is_on_reg && maxrun_hit)
                begin
                    ov_act_next   = 1'b0;
                    sw_req        = 1'b1;
                    sw_want       = 1'b0;
                    sw_why        = RSN_MAXRUN;
                    lk_act_next   = 1'b1;
                    lk_start_next = a_now_reg;
                end
                else if (ov_act_reg && !hold_done)
                begin
                    reason_next = RSN_MANUAL;
                end
                else
                begin
                    // override either inactive or just expired
                    ov_act_next = 1'b0;
                    if (!a_ok_reg || (lk_act_reg && !lock_done))
                    begin
                        sw_req  = is_on_reg;
                        sw_want = 1'b0;
                        sw_why  = a_ok_reg ? RSN_LOCKOUT : RSN_SENSOR;
                        reason_next = sw_why;
                    end
                    else
                    begin
                        lk_act_next = 1'b0;
                        if (hyst_want == is_on_reg)
                        begin
                            reason_next = hyst_why;
                        end
                        else if (!dwell_done)
                        begin
                            reason_next = RSN_DWELL;
                        end
                        else
                        begin
                            sw_req  = 1'b1;
                            sw_want = hyst_want;
                            sw_why  = hyst_why;
                        end
                    end
                end
            end
            OP_SET, OP_TOGGLE:
            begin
                lk_act_next   = 1'b0;
                ov_act_next   = 1'b1;
                ov_start_next = a_now_reg;
                sw_req        = (man_want != is_on_reg);
                sw_want       = man_want;
                sw_why        = RSN_MANUAL;
                force_manual  = 1'b1;
            end
            OP_AUTO:
            begin
                ov_act_next = 1'b0;
                reason_next = RSN_BOOT;
            end
            default: ;
        endcase

        if (sw_req)
        begin
            last_sw_next = a_now_reg;
            if (a_rdy_reg)
            begin
                is_on_next  = sw_want;
                reason_next = sw_why;
                if (sw_want)
                begin
                    on_since_next = a_now_reg;
                end
                b_stat_next.fire       = 1'b1;
                b_stat_next.fire_level = sw_want;
            end
            else
            begin
                reason_next = RSN_NOCODE;
            end
        end

        // manual ops report manual even after a failed attempt
        if (force_manual)
        begin
            reason_next = RSN_MANUAL;
        end

        b_stat_next.machine_on = is_on_next;
        b_stat_next.overriding = ov_act_next;
        b_stat_next.reason     = reason_next;
        b_stat_next.lockout    = lk_act_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_on_reg    <= 1'b0;
            reason_reg   <= RSN_BOOT;
            last_sw_reg  <= 32'd0;
            on_since_reg <= 32'd0;
            ov_act_reg   <= 1'b0;
            ov_start_reg <= 32'd0;
            lk_act_reg   <= 1'b0;
            lk_start_reg <= 32'd0;
        end
        else if (init_wr)
        begin
            is_on_reg <= pwdata[0];
        end
        else if (a_adv)
        begin
            is_on_reg    <= is_on_next;
            reason_reg   <= reason_next;
            last_sw_reg  <= last_sw_next;
            on_since_reg <= on_since_next;
            ov_act_reg   <= ov_act_next;
            ov_start_reg <= ov_start_next;
            lk_act_reg   <= lk_act_next;
            lk_start_reg <= lk_start_next;
        end
    end

    // ---------------- decision register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            b_stat_reg <= b_stat_next;
            b_dage_reg <= pos_ms(a_now_reg - last_sw_next);
            b_dov_reg  <= pos_ms(a_now_reg - ov_start_next);
            b_dlk_reg  <= pos_ms(a_now_reg - lk_start_next);
        end
    end

    // ---------------- seconds conversion ----------------
    hhg_sec_div u_div_age (
        .clk (clk),
        .en  (c_ready),
        .d   (b_dage_reg),
        .q   (c_age)
    );

    hhg_sec_div u_div_ov (
        .clk (clk),
        .en  (c_ready),
        .d   (b_dov_reg),
        .q   (c_ov_used)
    );

    hhg_sec_div u_div_lk (
        .clk (clk),
        .en  (c_ready),
        .d   (b_dlk_reg),
        .q   (c_lk_used)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
        begin
            c_stat_reg <= b_stat_reg;
        end
    end

    // ---------------- result register ----------------
    logic [19:0] ov_left, dwell_left, lk_left;

    always_comb
    begin
        ov_left = 20'd0;
        if (c_stat_reg.overriding && (c_ov_used < {2'b00, cfg.hold_sec}))
        begin
            ov_left = cfg.hold_sec - c_ov_used[19:0];
        end
        dwell_left = 20'd0;
        if (c_age < {2'b00, cfg.dwell_limit_sec})
        begin
            dwell_left = cfg.dwell_limit_sec - c_age[19:0];
        end
        lk_left = 20'd0;
        if (c_stat_reg.lockout && (c_lk_used < {2'b00, cfg.lock_sec}))
        begin
            lk_left = cfg.lock_sec - c_lk_used[19:0];
        end
        d_data_next = {6'd0, lk_left, dwell_left, ov_left, c_age,
                       c_stat_reg.fire_level, c_stat_reg.fire, c_stat_reg.reason,
                       c_stat_reg.overriding, c_stat_reg.machine_on};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            d_data_reg <= d_data_next;
        end
    end

    // ---------------- checks ----------------
    // a successful fire never reports a missing code
    a_fire_not_nocode: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[6]) |-> (m_axis_tdata[5:2] != RSN_NOCODE))
        else $error("fire with no-code reason");

    // a fire commands the believed state
    a_fire_level: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6] ? (m_axis_tdata[7] == m_axis_tdata[0])
                                           : !m_axis_tdata[7]))
        else $error("fire level inconsistent with state");

    // override and refill lockout never hold at once
    a_ov_lk_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ov_act_reg && lk_act_reg))
        else $error("override and lockout both active");

    // state moves only on a decision or a restore write
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(a_adv) && !$past(init_wr)) |-> $stable(is_on_reg))
        else $error("believed state changed without an item");

endmodule : humidifier_hysteresis_guard_top
`default_nettype wire

>>> hdl/hhg_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhg_cfg
// APB register file; also keeps each time limit pre-scaled to milliseconds.
// ----------------------------------------------------------------------------
module hhg_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [hhg_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output      logic [31:0]               prdata,
    output      logic                      pready,
    output      hhg_pkg::cfg_t             cfg,
    output      logic                      init_wr
);
    import hhg_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;
    logic [29:0] wr_ms;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_ms  = 30'(pwdata[19:0]) * 30'(MS_PER_SEC);
    assign cfg    = cfg_reg;
    assign init_wr = wr_en && (idx == REG_INITIAL_ON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_limit_sec   <= 20'd7200;
            cfg_reg.max_run_ms      <= 30'd7200000;
            cfg_reg.hold_sec        <= 20'd3600;
            cfg_reg.hold_ms         <= 30'd3600000;
            cfg_reg.lock_sec        <= 20'd1800;
            cfg_reg.lock_ms         <= 30'd1800000;
            cfg_reg.dwell_limit_sec <= 20'd300;
            cfg_reg.dwell_ms        <= 30'd300000;
            cfg_reg.on_below        <= 10'd450;
            cfg_reg.off_above       <= 10'd600;
            cfg_reg.initial_on      <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_MAX_RUN:
                begin
                    cfg_reg.run_limit_sec <= pwdata[19:0];
                    cfg_reg.max_run_ms    <= wr_ms;
                end
                REG_HOLD:
                begin
                    cfg_reg.hold_sec <= pwdata[19:0];
                    cfg_reg.hold_ms  <= wr_ms;
                end
                REG_LOCKOUT:
                begin
                    cfg_reg.lock_sec <= pwdata[19:0];
                    cfg_reg.lock_ms  <= wr_ms;
                end
                REG_DWELL:
                begin
                    cfg_reg.dwell_limit_sec <= pwdata[19:0];
                    cfg_reg.dwell_ms        <= wr_ms;
                end
                REG_ON_BELOW:   cfg_reg.on_below   <= pwdata[9:0];
                REG_OFF_ABOVE:  cfg_reg.off_above  <= pwdata[9:0];
                REG_INITIAL_ON: cfg_reg.initial_on <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MAX_RUN:    prdata = {12'd0, cfg_reg.run_limit_sec};
            REG_HOLD:       prdata = {12'd0, cfg_reg.hold_sec};
            REG_LOCKOUT:    prdata = {12'd0, cfg_reg.lock_sec};
            REG_DWELL:      prdata = {12'd0, cfg_reg.dwell_limit_sec};
            REG_ON_BELOW:   prdata = {22'd0, cfg_reg.on_below};
            REG_OFF_ABOVE:  prdata = {22'd0, cfg_reg.off_above};
            REG_INITIAL_ON: prdata = {31'd0, cfg_reg.initial_on};
            default:        prdata = 32'd0;
        endcase
    end

endmodule : hhg_cfg
`default_nettype wire

>>> hdl/hhg_sec_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhg_sec_div
// Registered milliseconds-to-seconds conversion: q = d / 1000.
// ----------------------------------------------------------------------------
module hhg_sec_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] d,
    output      logic [21:0] q
);
    import hhg_pkg::*;

    logic [27:0] x;
    logic [56:0] prod;
    logic [21:0] q_reg;

    // d / 1000 = (d / 8) / 125
    assign x    = d[30:3];
    assign prod = 57'(x) * 57'(RECIP_125);
    assign q    = q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= prod[RECIP_SHIFT+21:RECIP_SHIFT];
        end
    end

endmodule : hhg_sec_div
`default_nettype wire
